@@ src/csls_pkg.sv @@
package csls_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CUR_BITS       = 16;
    localparam int MAG_BITS       = 15;
    localparam int TICK_BITS      = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_REV_CHARGE_TH = 3'd0,
        REG_REV_FULL_TH   = 3'd1,
        REG_FWD_CHARGE_TH = 3'd2,
        REG_FWD_FULL_TH   = 3'd3,
        REG_HALF_SEC      = 3'd4,
        REG_ONE_SEC       = 3'd5,
        REG_THREE_SEC     = 3'd6,
        REG_COLOR_DELAY   = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_FORWARD  = 3'd1,
        MODE_BACKWARD = 3'd2,
        MODE_BIDIR    = 3'd3
    } ctrl_mode_t;

    typedef enum logic [3:0] {
        CS_PRE   = 4'd0,
        CS_CC    = 4'd1,
        CS_CV    = 4'd2,
        CS_FLOAT = 4'd3,
        CS_FULL  = 4'd4,
        CS_STOP  = 4'd5,
        CS_IDLE  = 4'd6,
        CS_FAULT = 4'd7,
        CS_POWER = 4'd8
    } charge_state_t;

    localparam logic [TICK_BITS-1:0] HALF_SEC_RESET    = 16'd500;
    localparam logic [TICK_BITS-1:0] ONE_SEC_RESET     = 16'd1000;
    localparam logic [TICK_BITS-1:0] THREE_SEC_RESET   = 16'd3000;
    localparam logic [TICK_BITS-1:0] COLOR_DELAY_RESET = 16'd200;

    typedef struct packed {
        logic [MAG_BITS-1:0]  rev_charge_th;
        logic [MAG_BITS-1:0]  rev_full_th;
        logic [MAG_BITS-1:0]  fwd_charge_th;
        logic [MAG_BITS-1:0]  fwd_full_th;
        logic [TICK_BITS-1:0] half_sec;
        logic [TICK_BITS-1:0] one_sec;
        logic [TICK_BITS-1:0] three_sec;
        logic [TICK_BITS-1:0] color_delay;
    } cfg_t;

    // saturated magnitude of a signed current
    function automatic logic [MAG_BITS-1:0] cur_magnitude(input logic [CUR_BITS-1:0] raw);
        logic [CUR_BITS-1:0] neg;
        begin
            neg = ~raw + 16'd1;
            if (!raw[CUR_BITS-1])
            begin
                cur_magnitude = raw[MAG_BITS-1:0];
            end
            else if (neg[CUR_BITS-1])
            begin
                cur_magnitude = '1;
            end
            else
            begin
                cur_magnitude = neg[MAG_BITS-1:0];
            end
        end
    endfunction

endpackage

@@ src/csls_cfg_regs.sv @@
module csls_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [csls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [csls_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output csls_pkg::cfg_t                      cfg
);

    csls_pkg::cfg_t cfg_reg;
    csls_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (csls_pkg::cfg_reg_t'(cfg_index))
                csls_pkg::REG_REV_CHARGE_TH:
                    cfg_next.rev_charge_th = cfg_data[csls_pkg::MAG_BITS-1:0];
                csls_pkg::REG_REV_FULL_TH:
                    cfg_next.rev_full_th = cfg_data[csls_pkg::MAG_BITS-1:0];
                csls_pkg::REG_FWD_CHARGE_TH:
                    cfg_next.fwd_charge_th = cfg_data[csls_pkg::MAG_BITS-1:0];
                csls_pkg::REG_FWD_FULL_TH:
                    cfg_next.fwd_full_th = cfg_data[csls_pkg::MAG_BITS-1:0];
                csls_pkg::REG_HALF_SEC:
                    cfg_next.half_sec = cfg_data;
                csls_pkg::REG_ONE_SEC:
                    cfg_next.one_sec = cfg_data;
                csls_pkg::REG_THREE_SEC:
                    cfg_next.three_sec = cfg_data;
                csls_pkg::REG_COLOR_DELAY:
                    cfg_next.color_delay = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rev_charge_th <= '0;
            cfg_reg.rev_full_th   <= '0;
            cfg_reg.fwd_charge_th <= '0;
            cfg_reg.fwd_full_th   <= '0;
            cfg_reg.half_sec      <= csls_pkg::HALF_SEC_RESET;
            cfg_reg.one_sec       <= csls_pkg::ONE_SEC_RESET;
            cfg_reg.three_sec     <= csls_pkg::THREE_SEC_RESET;
            cfg_reg.color_delay   <= csls_pkg::COLOR_DELAY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/charger_status_led_sequencer_unit.sv @@
// Charger status lamp sequencer. Each input item is one tick (nominally 1 ms)
// and yields exactly one result item: three mode lamps decoded from ctrl_mode
// and a red/green bicolor lamp driven from the fault flag, the charge state and,
// in the power state, the absolute current against the selected thresholds.
// An item passes through the input register and then the result register, and
// one item is taken every cycle; the only limit is the output stall, which
// backs up through both registers. The user must write the configuration
// registers through the cfg port only while no item is in flight; the block
// itself does not enforce this. COUNT_BITS sets the width of the blink and
// delay counters, which saturate at their top value.
module charger_status_led_sequencer_unit
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write_en,
    input  logic [csls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [csls_pkg::CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          ctrl_mode,
    input  logic [3:0]                          charge_state,
    input  logic                                fault_active,
    input  logic                                reverse_path,
    input  logic signed [15:0]                  low_side_current,
    input  logic signed [15:0]                  high_side_current,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                mode_red_on,
    output logic                                mode_green_on,
    output logic                                mode_yellow_on,
    output logic                                bicolor_is_green,
    output logic                                bicolor_lit
);

    localparam int CMP_W = (COUNT_BITS > csls_pkg::TICK_BITS) ? COUNT_BITS
                                                              : csls_pkg::TICK_BITS;

    csls_pkg::cfg_t cfg;

    csls_cfg_regs u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // input register
    logic                         s1_valid_reg;
    logic [2:0]                   s1_mode_reg;
    logic [3:0]                   s1_cstate_reg;
    logic                         s1_fault_reg;
    logic [csls_pkg::MAG_BITS-1:0] s1_cur_reg;
    logic [csls_pkg::MAG_BITS-1:0] s1_chg_th_reg;
    logic [csls_pkg::MAG_BITS-1:0] s1_full_th_reg;

    // state
    logic [COUNT_BITS-1:0] fault_cnt_reg, fault_cnt_next;
    logic                  fault_lvl_reg, fault_lvl_next;
    logic [COUNT_BITS-1:0] shared_cnt_reg, shared_cnt_next;
    logic [COUNT_BITS-1:0] red_cnt_reg, red_cnt_next;
    logic                  green_reg, green_next;
    logic                  lit_reg, lit_next;

    // result register
    logic                  out_valid_reg;
    logic                  red_on_reg, green_on_reg, yellow_on_reg;
    logic                  bi_green_reg, bi_lit_reg;
    logic                  bi_green_next, bi_lit_next;

    logic adv;
    logic in_take;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !adv;
    assign in_take  = in_valid && !in_stall;

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
        bump = (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic reached(input logic [COUNT_BITS-1:0] c,
                                     input logic [csls_pkg::TICK_BITS-1:0] lim);
        reached = CMP_W'(c) >= CMP_W'(lim);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv || !s1_valid_reg)
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg   <= ctrl_mode;
            s1_cstate_reg <= charge_state;
            s1_fault_reg  <= fault_active;
            if (reverse_path)
            begin
                s1_cur_reg     <= csls_pkg::cur_magnitude(high_side_current);
                s1_chg_th_reg  <= cfg.rev_charge_th;
                s1_full_th_reg <= cfg.rev_full_th;
            end
            else
            begin
                s1_cur_reg     <= csls_pkg::cur_magnitude(low_side_current);
                s1_chg_th_reg  <= cfg.fwd_charge_th;
                s1_full_th_reg <= cfg.fwd_full_th;
            end
        end
    end

    always_comb
    begin
        fault_cnt_next  = fault_cnt_reg;
        fault_lvl_next  = fault_lvl_reg;
        shared_cnt_next = shared_cnt_reg;
        red_cnt_next    = red_cnt_reg;
        green_next      = green_reg;
        lit_next        = lit_reg;
        bi_green_next   = green_reg;
        bi_lit_next     = lit_reg;

        if (s1_fault_reg)
        begin
            fault_cnt_next = bump(fault_cnt_reg);
            if (reached(fault_cnt_next, cfg.half_sec))
            begin
                fault_cnt_next = '0;
                fault_lvl_next = !fault_lvl_reg;
            end
            bi_green_next = 1'b0;
            bi_lit_next   = fault_lvl_next;
        end
        else
        begin
            case (s1_cstate_reg) inside
                csls_pkg::CS_PRE, csls_pkg::CS_STOP, csls_pkg::CS_IDLE,
                csls_pkg::CS_FAULT:
                begin
                    green_next      = (s1_cstate_reg == csls_pkg::CS_STOP);
                    shared_cnt_next = bump(shared_cnt_reg);
                    if ((s1_cstate_reg == csls_pkg::CS_IDLE &&
                         reached(shared_cnt_next, cfg.one_sec)) ||
                        (s1_cstate_reg == csls_pkg::CS_FAULT &&
                         reached(shared_cnt_next, cfg.half_sec)) ||
                        ((s1_cstate_reg == csls_pkg::CS_PRE ||
                          s1_cstate_reg == csls_pkg::CS_STOP) &&
                         reached(shared_cnt_next, cfg.three_sec)))
                    begin
                        shared_cnt_next = '0;
                        lit_next        = !lit_reg;
                    end
                end
                csls_pkg::CS_CC, csls_pkg::CS_CV:
                begin
                    green_next = 1'b0;
                    lit_next   = 1'b1;
                end
                csls_pkg::CS_FLOAT, csls_pkg::CS_FULL:
                begin
                    green_next = 1'b1;
                    lit_next   = 1'b1;
                end
                csls_pkg::CS_POWER:
                begin
                    if (green_reg && s1_cur_reg > s1_chg_th_reg)
                    begin
                        red_cnt_next    = '0;
                        shared_cnt_next = bump(shared_cnt_reg);
                    end
                    else if (!green_reg && s1_cur_reg < s1_full_th_reg)
                    begin
                        shared_cnt_next = '0;
                        red_cnt_next    = bump(red_cnt_reg);
                    end
                    if (reached(shared_cnt_next, cfg.color_delay))
                    begin
                        green_next      = 1'b0;
                        shared_cnt_next = '0;
                    end
                    if (reached(red_cnt_next, cfg.color_delay))
                    begin
                        green_next   = 1'b1;
                        red_cnt_next = '0;
                    end
                    lit_next = 1'b1;
                end
                default:
                begin
                    green_next = green_reg;
                end
            endcase
            bi_green_next = green_next;
            bi_lit_next   = lit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_cnt_reg  <= '0;
            fault_lvl_reg  <= 1'b0;
            shared_cnt_reg <= '0;
            red_cnt_reg    <= '0;
            green_reg      <= 1'b0;
            lit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                fault_cnt_reg  <= fault_cnt_next;
                fault_lvl_reg  <= fault_lvl_next;
                shared_cnt_reg <= shared_cnt_next;
                red_cnt_reg    <= red_cnt_next;
                green_reg      <= green_next;
                lit_reg        <= lit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            red_on_reg    <= (s1_mode_reg == csls_pkg::MODE_BACKWARD);
            green_on_reg  <= (s1_mode_reg == csls_pkg::MODE_FORWARD);
            yellow_on_reg <= (s1_mode_reg == csls_pkg::MODE_BIDIR);
            bi_green_reg  <= bi_green_next;
            bi_lit_reg    <= bi_lit_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign mode_red_on      = red_on_reg;
    assign mode_green_on    = green_on_reg;
    assign mode_yellow_on   = yellow_on_reg;
    assign bicolor_is_green = bi_green_reg;
    assign bicolor_lit      = bi_lit_reg;

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !s1_valid_reg) |=> !out_valid)
        else $error("result repeated after drain");

    a_fault_red: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && adv && s1_fault_reg) |=> (out_valid && !bicolor_is_green))
        else $error("fault item not shown red");

    a_mode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({mode_red_on, mode_green_on, mode_yellow_on}))
        else $error("more than one mode lamp lit");

    a_steady_lit: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && adv && !s1_fault_reg &&
         (s1_cstate_reg == csls_pkg::CS_CC || s1_cstate_reg == csls_pkg::CS_CV ||
          s1_cstate_reg == csls_pkg::CS_FLOAT || s1_cstate_reg == csls_pkg::CS_FULL ||
          s1_cstate_reg == csls_pkg::CS_POWER)) |=> bicolor_lit)
        else $error("steady charge state not lit");
`endif

endmodule
